// ===== rtl/core/dpr_pkg.sv =====
// ----------------------------------------------------------------------------
// dpr_pkg
// Types, codes and helpers shared by the debug packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dpr_pkg;

  localparam int unsigned MAX_LEN = 512;

  localparam int unsigned LEN_W   = 10;
  localparam int unsigned RETRY_W = 4;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned OUT_W   = 40;
  localparam int unsigned CFG_W   = 10;

  localparam logic [DATA_W-1:0] CH_START = 8'h24;  // '$'
  localparam logic [DATA_W-1:0] CH_END   = 8'h23;  // '#'
  localparam logic [DATA_W-1:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [DATA_W-1:0] CH_NAK   = 8'h2D;  // '-'

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_RETRY   = 2'd2;
  localparam logic [1:0] KIND_FAILED  = 2'd3;

  localparam logic [0:0] REG_MAX_LEN     = 1'b0;
  localparam logic [0:0] REG_MAX_RETRIES = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]   max_len;
    logic [RETRY_W-1:0] max_retries;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [DATA_W-1:0] payload_byte;
    logic [LEN_W-1:0]  packet_length;
    logic              reply_valid;
    logic [DATA_W-1:0] reply_byte;
    logic [DATA_W-1:0] computed_sum;
  } result_t;

  function automatic logic [3:0] hex_value(input logic [DATA_W-1:0] c);
    logic [DATA_W-1:0] d;
    begin
      d = 8'd0;
      if (c inside {[8'h30:8'h39]}) begin
        d = c - 8'h30;
      end else if (c inside {[8'h41:8'h46]}) begin
        d = c - 8'h37;
      end else if (c inside {[8'h61:8'h66]}) begin
        d = c - 8'h57;
      end
      hex_value = d[3:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/debug_packet_receiver_top.sv =====
// ----------------------------------------------------------------------------
// debug_packet_receiver_top
// Debugger serial packet receiver: framing, checksum check, ack/nak replies.
// ----------------------------------------------------------------------------
// One received byte per request, one byte per cycle sustained. A byte passes
// an input register and the framing engine into an output register; bytes
// that make no result (framing and checksum digits) still pass through the
// engine. Throughput is set only by out_tready backpressure.
`default_nettype none

module debug_packet_receiver_top
  import dpr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata,  // [7:0] payload_byte, [17:8] packet_length,
                                             // [18] reply_valid, [26:19] reply_byte,
                                             // [34:27] computed_sum, [39:35] zero
  output logic [1:0]             out_tuser,  // [1:0] kind
  input  wire logic              cfg_wr_en,
  input  wire logic [0:0]        cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wr_data
);

  cfg_t              cfg_r;
  logic              in_valid_r;
  logic [DATA_W-1:0] in_byte_r;
  logic              step;
  result_t           res;
  result_t           out_r;
  logic              out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_len     <= 10'd512;
      cfg_r.max_retries <= 4'd3;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MAX_LEN:     cfg_r.max_len     <= cfg_wr_data;
        REG_MAX_RETRIES: cfg_r.max_retries <= cfg_wr_data[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  dpr_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {5'd0, out_r.computed_sum, out_r.reply_byte, out_r.reply_valid,
                       out_r.packet_length, out_r.payload_byte};

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_PAYLOAD |-> !out_r.reply_valid && out_r.packet_length == '0)
    else $error("payload result carries verdict fields");

  a_reply_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_r.reply_valid |-> out_tuser == KIND_GOOD || out_tuser == KIND_RETRY)
    else $error("reply on wrong kind");

  a_no_step_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !step)
    else $error("engine advanced with no byte");

endmodule

`default_nettype wire

// ===== rtl/core/dpr_parse.sv =====
// ----------------------------------------------------------------------------
// dpr_parse
// Per-byte framing engine: holds packet state and forms at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dpr_parse
  import dpr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [DATA_W-1:0] rx_byte,
  input  wire cfg_t              cfg,
  output result_t                res
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_LO   = 2'd3;

  localparam logic [16:0] MAX_LEN_W = 17'(MAX_LEN);

  logic [1:0]         phase_r, phase_nxt;
  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [DATA_W-1:0]  sum_r, sum_nxt;
  logic [3:0]         hi_r, hi_nxt;
  logic [RETRY_W-1:0] retry_r, retry_nxt;
  logic [LEN_W-1:0]   limit;
  logic [DATA_W-1:0]  got;

  assign limit = ({7'd0, cfg.max_len} > MAX_LEN_W) ? MAX_LEN_W[LEN_W-1:0] : cfg.max_len;
  assign got   = {hi_r, hex_value(rx_byte)};

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    hi_nxt    = hi_r;
    retry_nxt = retry_r;
    res       = '0;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == CH_START) begin
          phase_nxt = PH_BODY;
          count_nxt = '0;
          sum_nxt   = '0;
        end
      end
      PH_BODY: begin
        if (count_r >= limit) begin
          hi_nxt    = hex_value(rx_byte);
          phase_nxt = PH_LO;
        end else if (rx_byte == CH_END) begin
          phase_nxt = PH_HI;
        end else begin
          count_nxt        = count_r + 1'b1;
          sum_nxt          = sum_r + rx_byte;
          res.valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
        end
      end
      PH_HI: begin
        hi_nxt    = hex_value(rx_byte);
        phase_nxt = PH_LO;
      end
      default: begin
        phase_nxt         = PH_HUNT;
        res.valid         = 1'b1;
        res.packet_length = count_r;
        res.computed_sum  = sum_r;
        if (got == sum_r) begin
          retry_nxt       = '0;
          res.kind        = KIND_GOOD;
          res.reply_valid = 1'b1;
          res.reply_byte  = CH_ACK;
        end else if (retry_r < cfg.max_retries) begin
          retry_nxt       = retry_r + 1'b1;
          res.kind        = KIND_RETRY;
          res.reply_valid = 1'b1;
          res.reply_byte  = CH_NAK;
        end else begin
          retry_nxt = '0;
          res.kind  = KIND_FAILED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
      sum_r   <= '0;
      hi_r    <= '0;
      retry_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      hi_r    <= hi_nxt;
      retry_r <= retry_nxt;
    end
  end

  a_verdict_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_LO |=> phase_r == PH_HUNT)
    else $error("verdict did not return to hunt");

  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid && res.kind == KIND_PAYLOAD |=> count_r == $past(count_r) + 1'b1)
    else $error("payload byte not counted");

endmodule

`default_nettype wire

// ===== test/debug_packet_receiver_checker.sv =====
// ----------------------------------------------------------------------------
// debug_packet_receiver_checker
// Watches the byte, result and register ports of the packet receiver. Keeps
// its own copy of the framing state and the settings, works out the result
// that each accepted byte must give and compares the results in order,
// field by field. Counts mismatches and the results still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module debug_packet_receiver_checker
  import dpr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] rx_byte
  input  wire logic             out_tvalid,
  input  wire logic             out_tready,
  input  wire logic [OUT_W-1:0] out_tdata,  // [7:0] payload_byte, [17:8] packet_length,
                                            // [18] reply_valid, [26:19] reply_byte,
                                            // [34:27] computed_sum
  input  wire logic [1:0]       out_tuser,  // [1:0] kind
  input  wire logic             cfg_wr_en,
  input  wire logic [0:0]       cfg_addr,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);

  typedef enum logic [1:0] {HUNT, BODY, SUM_HI, SUM_LO} frame_phase_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] payload_byte;
    logic [LEN_W-1:0]  packet_length;
    logic              reply_valid;
    logic [DATA_W-1:0] reply_byte;
    logic [DATA_W-1:0] computed_sum;
  } reply_t;

  reply_t             owed_replies[$];
  frame_phase_e       phase;
  logic [LEN_W-1:0]   body_count;
  logic [DATA_W-1:0]  body_sum;
  logic [3:0]         sum_high;
  logic [RETRY_W-1:0] naks_sent;
  logic [LEN_W-1:0]   len_limit;
  logic [RETRY_W-1:0] nak_limit;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c[3:0];
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic void frame_byte(input logic [7:0] b);
    logic [LEN_W-1:0]  lim;
    logic [DATA_W-1:0] got;
    reply_t            r;
    lim = (len_limit > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_limit;
    r = '0;
    case (phase)
      HUNT: begin
        if (b == CH_START) begin
          phase = BODY;
          body_count = '0;
          body_sum = '0;
        end
      end
      BODY: begin
        if (body_count >= lim) begin
          sum_high = digit_of(b);
          phase = SUM_LO;
        end else if (b == CH_END) begin
          phase = SUM_HI;
        end else begin
          body_count = body_count + 1'b1;
          body_sum = body_sum + b;
          r.kind = KIND_PAYLOAD;
          r.payload_byte = b;
          owed_replies.push_back(r);
        end
      end
      SUM_HI: begin
        sum_high = digit_of(b);
        phase = SUM_LO;
      end
      default: begin
        got = {sum_high, digit_of(b)};
        phase = HUNT;
        r.packet_length = body_count;
        r.computed_sum = body_sum;
        if (got == body_sum) begin
          naks_sent = '0;
          r.kind = KIND_GOOD;
          r.reply_valid = 1'b1;
          r.reply_byte = CH_ACK;
        end else if (naks_sent < nak_limit) begin
          naks_sent = naks_sent + 1'b1;
          r.kind = KIND_RETRY;
          r.reply_valid = 1'b1;
          r.reply_byte = CH_NAK;
        end else begin
          naks_sent = '0;
          r.kind = KIND_FAILED;
        end
        owed_replies.push_back(r);
      end
    endcase
  endfunction

  function automatic void report_mismatch(input string what, input reply_t want,
                                          input reply_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected kind %0d byte %02h len %0d reply %0d/%02h sum %02h", what,
               want.kind, want.payload_byte, want.packet_length, want.reply_valid,
               want.reply_byte, want.computed_sum);
      $display("  got kind %0d byte %02h len %0d reply %0d/%02h sum %02h",
               seen.kind, seen.payload_byte, seen.packet_length, seen.reply_valid,
               seen.reply_byte, seen.computed_sum);
    end
  endfunction

  always @(posedge clk) begin
    reply_t seen;
    reply_t want;
    if (!rst_n) begin
      owed_replies.delete();
      phase = HUNT;
      body_count = '0;
      body_sum = '0;
      sum_high = '0;
      naks_sent = '0;
      len_limit = LEN_W'(512);
      nak_limit = RETRY_W'(3);
      mismatches = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr == REG_MAX_LEN) len_limit = cfg_wr_data[LEN_W-1:0];
        else nak_limit = cfg_wr_data[RETRY_W-1:0];
      end
      if (in_tvalid && in_tready) frame_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        seen.kind = out_tuser;
        seen.payload_byte = out_tdata[7:0];
        seen.packet_length = out_tdata[17:8];
        seen.reply_valid = out_tdata[18];
        seen.reply_byte = out_tdata[26:19];
        seen.computed_sum = out_tdata[34:27];
        if (owed_replies.size() == 0) begin
          report_mismatch("unexpected result", '0, seen);
        end else begin
          want = owed_replies.pop_front();
          if (seen !== want) report_mismatch("result mismatch", want, seen);
        end
      end
    end
    outstanding = owed_replies.size();
  end

endmodule

`default_nettype wire

// ===== test/debug_packet_receiver_top_test.sv =====
// ----------------------------------------------------------------------------
// debug_packet_receiver_top_test
// Feeds framed packets, broken frames and line noise into the packet
// receiver under a series of length and retry settings, with random gaps
// and backpressure, and leaves checking to the checker beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module debug_packet_receiver_top_test;
  import dpr_pkg::*;

  typedef enum int {SUM_GOOD, SUM_FLIPPED, SUM_NONHEX, SUM_GARBLED} sum_style_e;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = 8'h00;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             cfg_wr_en = 1'b0;
  logic [0:0]       cfg_addr = REG_MAX_LEN;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  int unsigned      mismatches;
  int unsigned      outstanding;
  int unsigned      bytes_sent = 0;
  int unsigned      idle_cycles = 0;
  logic [9:0]       len_setting = 10'd512;
  bit               gaps_on = 1'b0;
  bit               long_hold = 1'b0;

  always #4 clk = ~clk;

  debug_packet_receiver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data)
  );

  debug_packet_receiver_checker frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == 4000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !held) begin
        held = 1'b1;
        out_tready = 1'b0;
        repeat (300) @(negedge clk);
        out_tready = 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] value);
    drain();
    repeat (4) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr = idx;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_MAX_LEN) len_setting = value;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return "0" + v;
    return (upper ? "A" : "a") + v - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
    return c;
  endfunction

  task automatic send_frame(input int n, input sum_style_e style);
    logic [7:0] b;
    logic [7:0] s;
    int         lim;
    int         body;
    bit         upper;
    lim = (len_setting > MAX_LEN) ? MAX_LEN : len_setting;
    body = (n < lim) ? n : lim;
    upper = 1'($urandom_range(0, 1));
    s = 8'h00;
    push_byte(CH_START);
    for (int i = 0; i < body; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_END) b = CH_START;
      s = s + b;
      push_byte(b);
    end
    if (n < lim) push_byte(CH_END);
    case (style)
      SUM_GOOD: begin
        push_byte(hex_char(s[7:4], upper));
        push_byte(hex_char(s[3:0], upper));
      end
      SUM_FLIPPED: begin
        s = s ^ (8'h01 << $urandom_range(0, 7));
        push_byte(hex_char(s[7:4], upper));
        push_byte(hex_char(s[3:0], upper));
      end
      SUM_NONHEX: begin
        if ($urandom_range(0, 1) == 0) begin
          push_byte(non_hex_char());
          push_byte(hex_char(s[3:0], upper));
        end else begin
          push_byte(hex_char(s[7:4], upper));
          push_byte(non_hex_char());
        end
      end
      default: begin
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    int         target;
    int         n;
    int         pick;
    int         lim;
    logic [7:0] b;
    sum_style_e style;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    gaps_on = 1'b1;

    // noise in hunt, empty packet, '$' and byte extremes inside a payload
    push_byte(CH_END);
    send_frame(0, SUM_GOOD);
    push_byte(CH_START);
    push_byte(CH_START);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_END);
    push_byte("2");
    push_byte("3");
    // non-hex high digit counts as zero
    push_byte(CH_START);
    push_byte(8'h05);
    push_byte(CH_END);
    push_byte("z");
    push_byte("5");
    // no retries left: straight to failure
    write_reg(REG_MAX_RETRIES, 10'd0);
    send_frame(0, SUM_FLIPPED);
    // zero limit: '#' is taken as the high digit
    write_reg(REG_MAX_LEN, 10'd0);
    push_byte(CH_START);
    push_byte(CH_END);
    push_byte("0");
    // limit lowered in the middle of a payload
    write_reg(REG_MAX_LEN, 10'd10);
    push_byte(CH_START);
    push_byte("a");
    push_byte("b");
    write_reg(REG_MAX_LEN, 10'd1);
    push_byte("c");
    push_byte("3");

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin write_reg(REG_MAX_LEN, 10'd1023); write_reg(REG_MAX_RETRIES, 10'd15); end
        1: begin write_reg(REG_MAX_LEN, 10'd1);    write_reg(REG_MAX_RETRIES, 10'd0);  end
        2: begin write_reg(REG_MAX_LEN, 10'd3);    write_reg(REG_MAX_RETRIES, 10'd2);  end
        3: begin write_reg(REG_MAX_LEN, 10'd512);  write_reg(REG_MAX_RETRIES, 10'd1);  end
        5: begin write_reg(REG_MAX_LEN, 10'd0);    write_reg(REG_MAX_RETRIES, 10'd3);  end
        6: begin write_reg(REG_MAX_LEN, 10'd100);  write_reg(REG_MAX_RETRIES, 10'd5);  end
        default: begin
          write_reg(REG_MAX_LEN, CFG_W'($urandom_range(4, 24)));
          write_reg(REG_MAX_RETRIES, CFG_W'($urandom_range(0, 15)));
        end
      endcase
      if (p == 7) gaps_on = 1'b0;
      if (p == 0) send_frame(600, SUM_GOOD);
      if (p == 6) begin
        long_hold = 1'b1;
        send_frame(90, SUM_GOOD);
      end
      lim = (len_setting > MAX_LEN) ? MAX_LEN : len_setting;
      target = bytes_sent + 110;
      while (bytes_sent < target) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_START) b = 8'h00;
            push_byte(b);
          end
        end else if (pick == 1) begin
          send_frame($urandom_range(0, 6), SUM_GARBLED);
        end else if (pick == 2) begin
          send_frame($urandom_range(0, 6), SUM_GOOD);
          drain();
        end else begin
          if ($urandom_range(0, 7) == 0) n = $urandom_range(0, (lim + 2 < 70) ? lim + 2 : 70);
          else n = $urandom_range(0, 12);
          pick = $urandom_range(0, 19);
          style = (pick < 12) ? SUM_GOOD : (pick < 17) ? SUM_FLIPPED : SUM_NONHEX;
          send_frame(n, style);
        end
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
